### sv/ssc_pkg.sv
`default_nettype none
package ssc_pkg;

    localparam int DUTY_W      = 14;
    localparam int FREQ_W      = 16;
    localparam int ACTION_W    = 2;
    localparam int STEP_W      = 3;
    localparam int CMD_W       = 2;
    localparam int PHASE_W     = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int NUM_PHASES  = 3;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [ACTION_W-1:0] ACT_STEP = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_INIT = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_STOP = 2'd2;

    localparam logic [STEP_W-1:0] STEP_MAX = 3'd5;

    localparam logic [CMD_W-1:0] CMD_FREQ = 2'd0;
    localparam logic [CMD_W-1:0] CMD_MODE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DUTY = 2'd2;

    localparam logic [1:0] MODE_SYNC    = 2'd0;
    localparam logic [1:0] MODE_COMP    = 2'd1;
    localparam logic [1:0] MODE_INVALID = 2'd3;

    localparam logic [1:0] SRC_PWM = 2'd0;
    localparam logic [1:0] SRC_MIN = 2'd1;
    localparam logic [1:0] SRC_OFF = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CEILING = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE    = 2'd2;

    localparam logic [DUTY_W-1:0] FLOOR_RESET   = 14'd200;
    localparam logic [DUTY_W-1:0] CEILING_RESET = 14'd9800;
    localparam logic [DUTY_W-1:0] IDLE_RESET    = 14'd5000;

    typedef struct packed {
        logic [DUTY_W-1:0] floor_duty;
        logic [DUTY_W-1:0] ceiling_duty;
        logic [DUTY_W-1:0] idle_duty;
    } cfg_t;

    // mask bit 0: frequency command, bits 1..3: phase U, V, W
    typedef struct packed {
        logic [NUM_PHASES:0]               mask;
        logic [FREQ_W-1:0]                 freq;
        logic [NUM_PHASES-1:0]             duty_only;
        logic [NUM_PHASES-1:0]             comp;
        logic [NUM_PHASES-1:0][DUTY_W-1:0] duty;
    } job_t;

    typedef struct packed {
        logic [NUM_PHASES-1:0][1:0] mode;
        logic [NUM_PHASES-1:0][1:0] src;
    } step_row_t;

    function automatic step_row_t step_row(input logic [STEP_W-1:0] idx);
        step_row_t r;
        case (idx)
            3'd0:
            begin
                r.mode = {MODE_COMP, MODE_SYNC, MODE_SYNC};
                r.src  = {SRC_OFF, SRC_MIN, SRC_PWM};
            end
            3'd1:
            begin
                r.mode = {MODE_SYNC, MODE_COMP, MODE_SYNC};
                r.src  = {SRC_MIN, SRC_OFF, SRC_PWM};
            end
            3'd2:
            begin
                r.mode = {MODE_SYNC, MODE_SYNC, MODE_COMP};
                r.src  = {SRC_MIN, SRC_PWM, SRC_OFF};
            end
            3'd3:
            begin
                r.mode = {MODE_COMP, MODE_SYNC, MODE_SYNC};
                r.src  = {SRC_OFF, SRC_PWM, SRC_MIN};
            end
            3'd4:
            begin
                r.mode = {MODE_SYNC, MODE_COMP, MODE_SYNC};
                r.src  = {SRC_PWM, SRC_OFF, SRC_MIN};
            end
            3'd5:
            begin
                r.mode = {MODE_SYNC, MODE_SYNC, MODE_COMP};
                r.src  = {SRC_PWM, SRC_MIN, SRC_OFF};
            end
            default:
            begin
                r.mode = {MODE_INVALID, MODE_INVALID, MODE_INVALID};
                r.src  = {SRC_OFF, SRC_OFF, SRC_OFF};
            end
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

### sv/ssc_req_if.sv
`default_nettype none
interface ssc_req_if;
    logic                          valid;
    logic                          ready;
    logic [ssc_pkg::ACTION_W-1:0]  action;
    logic [ssc_pkg::STEP_W-1:0]    step_index;
    logic [ssc_pkg::FREQ_W-1:0]    pwm_frequency;
    logic [ssc_pkg::DUTY_W-1:0]    duty_request;

    modport source (output valid, action, step_index, pwm_frequency, duty_request,
                    input ready);
    modport sink (input valid, action, step_index, pwm_frequency, duty_request,
                  output ready);
endinterface
`default_nettype wire

### sv/ssc_cmd_if.sv
`default_nettype none
interface ssc_cmd_if;
    logic                         valid;
    logic                         ready;
    logic [ssc_pkg::CMD_W-1:0]    command;
    logic [ssc_pkg::PHASE_W-1:0]  phase;
    logic                         complementary;
    logic [ssc_pkg::DUTY_W-1:0]   duty_value;
    logic [ssc_pkg::FREQ_W-1:0]   frequency_value;
    logic                         last;

    modport source (output valid, command, phase, complementary, duty_value,
                    frequency_value, last, input ready);
    modport sink (input valid, command, phase, complementary, duty_value,
                  frequency_value, last, output ready);
endinterface
`default_nettype wire

### sv/ssc_front.sv
`default_nettype none
module ssc_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire ssc_pkg::cfg_t cfg,
    ssc_req_if.sink            req,
    input  wire logic          q_ready,
    output ssc_pkg::job_t      q_job,
    output logic               q_push
);

    localparam int NP = ssc_pkg::NUM_PHASES;

    logic [ssc_pkg::FREQ_W-1:0]          kept_freq_reg, kept_freq_next;
    logic [NP-1:0][1:0]                  kept_mode_reg, kept_mode_next;
    logic [NP-1:0][ssc_pkg::DUTY_W-1:0]  kept_duty_reg, kept_duty_next;

    logic                         accept;
    logic [ssc_pkg::DUTY_W-1:0]   duty_lo;
    logic [ssc_pkg::DUTY_W-1:0]   pwm_duty;
    logic                         freq_chg;
    ssc_pkg::step_row_t           row;
    ssc_pkg::job_t                job;
    logic [NP-1:0][1:0]           upd_mode;
    logic [NP-1:0][ssc_pkg::DUTY_W-1:0] upd_duty;
    logic [ssc_pkg::FREQ_W-1:0]   upd_freq;
    logic [NP-1:0][1:0]           cmp_mode;
    logic [NP-1:0][ssc_pkg::DUTY_W-1:0] src_duty;

    assign req.ready = q_ready;
    assign accept    = req.valid && req.ready;

    assign duty_lo  = (req.duty_request < cfg.floor_duty) ? cfg.floor_duty : req.duty_request;
    assign pwm_duty = (duty_lo > cfg.ceiling_duty) ? cfg.ceiling_duty : duty_lo;
    assign freq_chg = req.pwm_frequency != kept_freq_reg;
    assign row      = ssc_pkg::step_row(req.step_index);

    always_comb
    begin
        job      = '0;
        upd_mode = kept_mode_reg;
        upd_duty = kept_duty_reg;
        upd_freq = kept_freq_reg;
        for (int ch = 0; ch < NP; ch++)
        begin
            cmp_mode[ch] = freq_chg ? ssc_pkg::MODE_INVALID : kept_mode_reg[ch];
            case (row.src[ch])
                ssc_pkg::SRC_PWM: src_duty[ch] = pwm_duty;
                ssc_pkg::SRC_MIN: src_duty[ch] = cfg.floor_duty;
                default:          src_duty[ch] = cfg.idle_duty;
            endcase
        end
        case (req.action)
            ssc_pkg::ACT_STEP:
            begin
                if (req.step_index <= ssc_pkg::STEP_MAX)
                begin
                    job.mask[0] = freq_chg;
                    job.freq    = req.pwm_frequency;
                    upd_freq    = req.pwm_frequency;
                    for (int ch = 0; ch < NP; ch++)
                    begin
                        job.comp[ch] = row.mode[ch][0];
                        job.duty[ch] = src_duty[ch];
                        if (row.mode[ch] != cmp_mode[ch])
                        begin
                            job.mask[ch+1] = 1'b1;
                            upd_mode[ch]   = row.mode[ch];
                            upd_duty[ch]   = src_duty[ch];
                        end
                        else if (row.src[ch] == ssc_pkg::SRC_PWM &&
                                 src_duty[ch] != kept_duty_reg[ch])
                        begin
                            job.mask[ch+1]    = 1'b1;
                            job.duty_only[ch] = 1'b1;
                            upd_duty[ch]      = src_duty[ch];
                        end
                    end
                end
            end
            ssc_pkg::ACT_INIT, ssc_pkg::ACT_STOP:
            begin
                for (int ch = 0; ch < NP; ch++)
                begin
                    job.mask[ch+1] = 1'b1;
                    job.comp[ch]   = 1'b1;
                    job.duty[ch]   = cfg.idle_duty;
                    if (req.action == ssc_pkg::ACT_INIT)
                    begin
                        upd_mode[ch] = ssc_pkg::MODE_INVALID;
                    end
                end
            end
            default:
            begin
                job = '0;
            end
        endcase
    end

    assign kept_freq_next = accept ? upd_freq : kept_freq_reg;
    assign kept_mode_next = accept ? upd_mode : kept_mode_reg;
    assign kept_duty_next = accept ? upd_duty : kept_duty_reg;

    assign q_job  = job;
    assign q_push = accept && (|job.mask);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kept_freq_reg <= '0;
            kept_mode_reg <= {NP{ssc_pkg::MODE_INVALID}};
            kept_duty_reg <= '0;
        end
        else
        begin
            kept_freq_reg <= kept_freq_next;
            kept_mode_reg <= kept_mode_next;
            kept_duty_reg <= kept_duty_next;
        end
    end

endmodule
`default_nettype wire

### sv/ssc_queue.sv
`default_nettype none
module ssc_queue #(
    parameter int DEPTH = ssc_pkg::QUEUE_DEPTH
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire ssc_pkg::job_t push_job,
    output logic               not_full,
    input  wire logic          pop,
    output ssc_pkg::job_t      head_job,
    output logic               not_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ssc_pkg::job_t      mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign not_full  = count_reg != CNT_W'(DEPTH);
    assign not_empty = count_reg != '0;
    assign head_job  = mem_reg[rd_ptr_reg];
    assign do_push   = push && not_full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

### sv/ssc_back.sv
`default_nettype none
module ssc_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire ssc_pkg::job_t q_job,
    input  wire logic          q_valid,
    output logic               q_pop,
    ssc_cmd_if.source          cmd
);

    localparam int NP = ssc_pkg::NUM_PHASES;

    ssc_pkg::job_t                 job_reg, job_next;
    logic [NP:0]                   mask_reg, mask_next;
    logic                          out_valid_reg, out_valid_next;
    logic [ssc_pkg::CMD_W-1:0]     command_reg, command_next;
    logic [ssc_pkg::PHASE_W-1:0]   phase_reg, phase_next;
    logic                          comp_reg, comp_next;
    logic [ssc_pkg::DUTY_W-1:0]    duty_reg, duty_next;
    logic [ssc_pkg::FREQ_W-1:0]    freq_reg, freq_next;
    logic                          last_reg, last_next;

    logic                          emit_ok;
    logic                          have;
    logic [1:0]                    sel;
    logic [NP:0]                   rest;
    logic [ssc_pkg::PHASE_W-1:0]   ph;
    logic [NP:0]                   mask_after;

    assign emit_ok = !out_valid_reg || cmd.ready;
    assign have    = |mask_reg;

    always_comb
    begin
        if (mask_reg[0])
        begin
            sel = 2'd0;
        end
        else if (mask_reg[1])
        begin
            sel = 2'd1;
        end
        else if (mask_reg[2])
        begin
            sel = 2'd2;
        end
        else
        begin
            sel = 2'd3;
        end
    end

    assign rest       = mask_reg & ~((NP+1)'(1) << sel);
    assign ph         = sel - 2'd1;
    assign mask_after = (have && emit_ok) ? rest : mask_reg;
    assign q_pop      = q_valid && (mask_after == '0);

    always_comb
    begin
        job_next       = q_pop ? q_job : job_reg;
        mask_next      = q_pop ? q_job.mask : mask_after;
        out_valid_next = cmd.ready ? 1'b0 : out_valid_reg;
        command_next   = command_reg;
        phase_next     = phase_reg;
        comp_next      = comp_reg;
        duty_next      = duty_reg;
        freq_next      = freq_reg;
        last_next      = last_reg;
        if (have && emit_ok)
        begin
            out_valid_next = 1'b1;
            last_next      = rest == '0;
            if (sel == 2'd0)
            begin
                command_next = ssc_pkg::CMD_FREQ;
                phase_next   = '0;
                comp_next    = 1'b0;
                duty_next    = '0;
                freq_next    = job_reg.freq;
            end
            else
            begin
                command_next = job_reg.duty_only[ph] ? ssc_pkg::CMD_DUTY : ssc_pkg::CMD_MODE;
                phase_next   = ph;
                comp_next    = job_reg.comp[ph];
                duty_next    = job_reg.duty[ph];
                freq_next    = '0;
            end
        end
    end

    assign cmd.valid           = out_valid_reg;
    assign cmd.command         = command_reg;
    assign cmd.phase           = phase_reg;
    assign cmd.complementary   = comp_reg;
    assign cmd.duty_value      = duty_reg;
    assign cmd.frequency_value = freq_reg;
    assign cmd.last            = last_reg;

    always_ff @(posedge clk)
    begin
        job_reg     <= job_next;
        command_reg <= command_next;
        phase_reg   <= phase_next;
        comp_reg    <= comp_next;
        duty_reg    <= duty_next;
        freq_reg    <= freq_next;
        last_reg    <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg      <= mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

### sv/six_step_commutation_cmd.sv
// Six-step commutation command generator.
// req channel: one request (step, init or stop) per handshake; a step carries
//   the commutation state, PWM frequency and requested duty.
// cmd channel: PWM timer commands (set frequency, set mode and duty, set duty
//   only), zero to four per request, the final one flagged by last.
// cfg port: cfg_we/cfg_index/cfg_data write duty floor, ceiling and idle duty.
// The front end classifies a request in the cycle it is taken and updates the
//   channel caches; a job queue of QUEUE_DEPTH entries feeds the back end,
//   which issues one command per cycle from a registered output stage.
// The first command of a request passes a queue entry, the back end's mask
//   and job registers and the output register before it is valid.
// Throughput: one command per cycle while cmd.ready holds, set by the single
//   output stage; requests are taken every cycle while the queue has room.
// Reset: config returns to 200/9800/5000, frequency cache to 0, mode cache
//   invalid, duty cache 0, queue and output empty.
// A stalled receiver holds the output; the queue fills and req.ready drops.
`default_nettype none
module six_step_commutation_cmd #(
    parameter int QUEUE_DEPTH = ssc_pkg::QUEUE_DEPTH
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [ssc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [ssc_pkg::DUTY_W-1:0]      cfg_data,
    ssc_req_if.sink                              req,
    ssc_cmd_if.source                            cmd
);

    ssc_pkg::cfg_t  cfg_reg, cfg_next;
    ssc_pkg::job_t  push_job, head_job;
    logic           push, pop, not_full, not_empty;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                ssc_pkg::CFG_FLOOR:   cfg_next.floor_duty   = cfg_data;
                ssc_pkg::CFG_CEILING: cfg_next.ceiling_duty = cfg_data;
                ssc_pkg::CFG_IDLE:    cfg_next.idle_duty    = cfg_data;
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.floor_duty   <= ssc_pkg::FLOOR_RESET;
            cfg_reg.ceiling_duty <= ssc_pkg::CEILING_RESET;
            cfg_reg.idle_duty    <= ssc_pkg::IDLE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    ssc_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .req     (req),
        .q_ready (not_full),
        .q_job   (push_job),
        .q_push  (push)
    );

    ssc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .not_full  (not_full),
        .pop       (pop),
        .head_job  (head_job),
        .not_empty (not_empty)
    );

    ssc_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_job   (head_job),
        .q_valid (not_empty),
        .q_pop   (pop),
        .cmd     (cmd)
    );

endmodule
`default_nettype wire
